>>> rtl/core/sfnt_table_directory_builder_top_defines.svh
// ---------------------------------------------------------------------------
// sfnt table directory builder assertion macros
// shared property shapes for the block's concurrent checks
// ---------------------------------------------------------------------------
`ifndef SFNT_TABLE_DIRECTORY_BUILDER_TOP_DEFINES_SVH
`define SFNT_TABLE_DIRECTORY_BUILDER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define STDB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define STDB_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

>>> rtl/core/stdb_pkg.sv
// ---------------------------------------------------------------------------
// stdb_pkg
// types and constants shared by the sfnt table directory builder
// ---------------------------------------------------------------------------
`default_nettype none

package stdb_pkg;

    localparam int MAX_TABLES   = 256;
    localparam int CNT_W        = 9;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] TAG_CFF      = 32'h4346_4620;
    localparam logic [31:0] VERSION_OTTO = 32'h4F54_544F;
    localparam logic [31:0] VERSION_TRUE = 32'h0001_0000;
    localparam logic [31:0] HEADER_BYTES = 32'd12;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    typedef struct packed {
        logic [31:0] table_tag;
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        table_end;
    } stdb_in_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] entry_tag;
        logic [31:0] checksum;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] sfnt_version;
        logic [15:0] num_tables;
        logic [15:0] search_range;
        logic [3:0]  entry_selector;
        logic [15:0] range_shift;
        logic        last;
    } stdb_out_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] checksum;
        logic [31:0] offset;
        logic [31:0] length;
        logic        run_end;
        logic        cff;
    } stdb_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stdb_q_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/stdb_front.sv
// ---------------------------------------------------------------------------
// stdb_front
// accepts table bytes, keeps checksum, length and offset, queues table jobs
// ---------------------------------------------------------------------------
`default_nettype none

module stdb_front import stdb_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [CNT_W-1:0]   cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire stdb_in_t           s_data,
    input  wire stdb_q_stat_t       q_stat,
    output logic                    push,
    output stdb_job_t               push_job,
    output logic [CNT_W-1:0]        eff_count
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      sum_reg, sum_next;
    logic [1:0]       pos_reg, pos_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      off_reg, off_next;
    logic [CNT_W-1:0] done_reg, done_next;
    logic             cff_reg, cff_next;

    logic             acc;
    logic [31:0]      sum_upd;
    logic [31:0]      len_upd;
    logic [1:0]       pos_upd;
    logic [CNT_W-1:0] done_inc;
    logic             run_end;
    logic             cff_upd;
    logic [CNT_W-1:0] cfg_eff;

    function automatic logic [31:0] base_offset(input logic [CNT_W-1:0] n);
        base_offset = HEADER_BYTES + (32'(n) << 4);
    endfunction

    assign s_ready   = !q_stat.full;
    assign acc       = s_valid && s_ready;
    assign eff_count = cnt_reg;

    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_eff = CNT_W'(1);
        end else if (cfg_wr_data > CNT_W'(MAX_TABLES)) begin
            cfg_eff = CNT_W'(MAX_TABLES);
        end else begin
            cfg_eff = cfg_wr_data;
        end
    end

    always_comb begin
        if (s_data.byte_present) begin
            sum_upd = sum_reg + (32'(s_data.data_byte) << {~pos_reg, 3'b000});
            len_upd = len_reg + 32'd1;
            pos_upd = pos_reg + 2'd1;
        end else begin
            sum_upd = sum_reg;
            len_upd = len_reg;
            pos_upd = pos_reg;
        end
        done_inc = done_reg + CNT_W'(1);
        run_end  = done_inc >= cnt_reg;
        cff_upd  = cff_reg || (s_data.table_tag == TAG_CFF);

        push              = acc && s_data.table_end;
        push_job.tag      = s_data.table_tag;
        push_job.checksum = sum_upd;
        push_job.offset   = off_reg;
        push_job.length   = len_upd;
        push_job.run_end  = run_end;
        push_job.cff      = cff_upd;

        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        off_next  = off_reg;
        done_next = done_reg;
        cff_next  = cff_reg;

        if (cfg_wr_en) begin
            cnt_next  = cfg_eff;
            sum_next  = '0;
            pos_next  = '0;
            len_next  = '0;
            off_next  = base_offset(cfg_eff);
            done_next = '0;
            cff_next  = 1'b0;
        end else if (acc) begin
            if (!s_data.table_end) begin
                sum_next = sum_upd;
                pos_next = pos_upd;
                len_next = len_upd;
            end else if (run_end) begin
                sum_next  = '0;
                pos_next  = '0;
                len_next  = '0;
                off_next  = base_offset(cnt_reg);
                done_next = '0;
                cff_next  = 1'b0;
            end else begin
                sum_next  = '0;
                pos_next  = '0;
                len_next  = '0;
                off_next  = off_reg + ((len_upd + 32'd3) & ~32'd3);
                done_next = done_inc;
                cff_next  = cff_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= CNT_W'(1);
            sum_reg  <= '0;
            pos_reg  <= '0;
            len_reg  <= '0;
            off_reg  <= base_offset(CNT_W'(1));
            done_reg <= '0;
            cff_reg  <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            off_reg  <= off_next;
            done_reg <= done_next;
            cff_reg  <= cff_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/stdb_queue.sv
// ---------------------------------------------------------------------------
// stdb_queue
// short job queue between the front and back parts
// ---------------------------------------------------------------------------
`default_nettype none

module stdb_queue import stdb_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire stdb_job_t    push_job,
    input  wire logic         pop,
    output stdb_job_t         pop_job,
    output stdb_q_stat_t      q_stat
);

    stdb_job_t             entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   cnt_reg, cnt_next;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        ptr_inc = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
    endfunction

    assign q_stat.full  = cnt_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign q_stat.empty = cnt_reg == '0;
    assign pop_job      = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QUEUE_CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/stdb_back.sv
// ---------------------------------------------------------------------------
// stdb_back
// turns queued table jobs into directory entries and the closing header
// ---------------------------------------------------------------------------
`default_nettype none

module stdb_back import stdb_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire stdb_q_stat_t       q_stat,
    input  wire stdb_job_t          pop_job,
    output logic                    pop,
    input  wire logic [CNT_W-1:0]   eff_count,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output stdb_out_t               m_data
);

    logic      m_valid_reg, m_valid_next;
    stdb_out_t m_data_reg, m_data_next;
    logic      pend_reg, pend_next;
    logic      pend_cff_reg, pend_cff_next;

    logic      slot_free;
    stdb_out_t entry_res;
    stdb_out_t header_res;
    logic [3:0]  sel;
    logic [15:0] pow2;
    logic [15:0] sr;

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign pop       = slot_free && !pend_reg && !q_stat.empty;

    always_comb begin
        sel = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (eff_count[i]) begin
                sel = 4'(i);
            end
        end
        pow2 = 16'd1 << sel;
        sr   = pow2 << 4;

        header_res                = '0;
        header_res.kind           = KIND_HEADER;
        header_res.sfnt_version   = pend_cff_reg ? VERSION_OTTO : VERSION_TRUE;
        header_res.num_tables     = 16'(eff_count);
        header_res.search_range   = sr;
        header_res.entry_selector = sel;
        header_res.range_shift    = (16'(eff_count) << 4) - sr;
        header_res.last           = 1'b1;

        entry_res           = '0;
        entry_res.kind      = KIND_ENTRY;
        entry_res.entry_tag = pop_job.tag;
        entry_res.checksum  = pop_job.checksum;
        entry_res.offset    = pop_job.offset;
        entry_res.length    = pop_job.length;
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        pend_next     = pend_reg;
        pend_cff_next = pend_cff_reg;
        if (slot_free) begin
            m_valid_next = 1'b0;
            if (pend_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = header_res;
                pend_next    = 1'b0;
            end else if (!q_stat.empty) begin
                m_valid_next  = 1'b1;
                m_data_next   = entry_res;
                pend_next     = pop_job.run_end;
                pend_cff_next = pop_job.cff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            pend_cff_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            pend_reg     <= pend_next;
            pend_cff_reg <= pend_cff_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sfnt_table_directory_builder_top.sv
// ---------------------------------------------------------------------------
// sfnt table directory builder
// Takes one byte of font table data per cycle and produces one directory
// entry per table and the sfnt header after the last table of a run. Input
// bytes are accepted at one per cycle whenever the four-entry job queue has
// room; each table end queues one job. The output register delivers one
// result per cycle while m_ready is high, and the run's closing header
// is one extra result. The queue absorbs it unless every table is a
// single item; then the input is held off while the header goes out.
// A write of table_count restarts the run.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sfnt_table_directory_builder_top_defines.svh"

module sfnt_table_directory_builder_top import stdb_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [CNT_W-1:0]   cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire stdb_in_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output stdb_out_t               m_data
);

    stdb_q_stat_t     q_stat;
    logic             push;
    stdb_job_t        push_job;
    logic             pop;
    stdb_job_t        pop_job;
    logic [CNT_W-1:0] eff_count;
    logic             out_entry;
    logic             out_header;
    logic             hdr_ok;

    stdb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_stat      (q_stat),
        .push        (push),
        .push_job    (push_job),
        .eff_count   (eff_count)
    );

    stdb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    stdb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .pop_job   (pop_job),
        .pop       (pop),
        .eff_count (eff_count),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign out_entry  = m_valid && (m_data.kind == KIND_ENTRY);
    assign out_header = m_valid && (m_data.kind == KIND_HEADER);
    assign hdr_ok     = m_data.last && (m_data.num_tables == 16'(eff_count));

    `STDB_ASSERT_NEVER(a_no_push_full, push && q_stat.full, "job pushed into a full queue")
    `STDB_ASSERT_NEVER(a_no_pop_empty, pop && q_stat.empty, "job popped from an empty queue")
    `STDB_ASSERT_IMPLIES(a_offset_aligned, out_entry, m_data.offset[1:0] == 2'b00, "offset unaligned")
    `STDB_ASSERT_IMPLIES(a_header_count, out_header, hdr_ok, "header count mismatch")

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfnt table directory builder testbench
// Streams tagged table bytes into the block and predicts every directory
// entry and closing sfnt header with an in-bench checksum and offset tally.
// Results are compared field by field as they arrive. Covers the table count
// extremes, mid-run restarts, absent bytes, random runs and output stalls.
// ---------------------------------------------------------------------------
module tb;
    import stdb_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned IDLE_PCT      = 13;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CNT_W-1:0]  cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    stdb_in_t          s_data;
    logic              m_valid;
    logic              m_ready;
    stdb_out_t         m_data;

    sfnt_table_directory_builder_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // directory tally
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      word_sum;
    logic [1:0]       lane;
    logic [31:0]      tbl_bytes;
    logic [31:0]      next_offset;
    int unsigned      closed_tables;
    bit               saw_cff;
    stdb_out_t        expected_records[$];

    int unsigned mismatches  = 0;
    int unsigned items_in    = 0;
    int unsigned entries_out = 0;
    int unsigned headers_out = 0;
    int unsigned otto_out    = 0;
    int unsigned peak_count  = 0;
    int unsigned rx_hold     = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned active_count();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_TABLES) return MAX_TABLES;
        return count_reg;
    endfunction

    function automatic void restart_tally();
        word_sum      = '0;
        lane          = '0;
        tbl_bytes     = '0;
        next_offset   = HEADER_BYTES + 32'(16 * active_count());
        closed_tables = 0;
        saw_cff       = 1'b0;
    endfunction

    function automatic void tally_item(stdb_in_t it);
        stdb_out_t   rec;
        stdb_out_t   hdr;
        int unsigned n;
        int unsigned pow2;
        int unsigned sel;
        logic [15:0] srange;
        if (it.byte_present) begin
            word_sum  += {24'd0, it.data_byte} << (24 - 8 * lane);
            lane      += 2'd1;
            tbl_bytes += 32'd1;
        end
        if (!it.table_end) return;
        rec           = '0;
        rec.kind      = KIND_ENTRY;
        rec.entry_tag = it.table_tag;
        rec.checksum  = word_sum;
        rec.offset    = next_offset;
        rec.length    = tbl_bytes;
        expected_records = {expected_records, rec};
        if (it.table_tag == TAG_CFF) saw_cff = 1'b1;
        next_offset  += (tbl_bytes + 32'd3) & ~32'd3;
        word_sum      = '0;
        lane          = '0;
        tbl_bytes     = '0;
        closed_tables++;
        n = active_count();
        if (closed_tables < n) return;
        pow2 = 1;
        sel  = 0;
        while (pow2 * 2 <= n) begin
            pow2 *= 2;
            sel++;
        end
        srange             = 16'(pow2 * 16);
        hdr                = '0;
        hdr.kind           = KIND_HEADER;
        hdr.sfnt_version   = saw_cff ? VERSION_OTTO : VERSION_TRUE;
        hdr.num_tables     = 16'(n);
        hdr.search_range   = srange;
        hdr.entry_selector = 4'(sel);
        hdr.range_shift    = 16'(n * 16) - srange;
        hdr.last           = 1'b1;
        expected_records = {expected_records, hdr};
        restart_tally();
    endfunction

    function automatic stdb_in_t mk_item(logic [31:0] tag, logic [7:0] b, logic present,
                                         logic close);
        stdb_in_t it;
        it.table_tag    = tag;
        it.data_byte    = b;
        it.byte_present = present;
        it.table_end    = close;
        return it;
    endfunction

    function automatic logic [31:0] pick_tag();
        return ($urandom_range(5) == 0) ? TAG_CFF : $urandom;
    endfunction

    // tag on a non-closing byte: mostly the table's own, sometimes anything
    function automatic logic [31:0] stray_tag(logic [31:0] tag);
        if ($urandom_range(7) != 0) return tag;
        return ($urandom_range(1) == 0) ? TAG_CFF : $urandom;
    endfunction

    function automatic int unsigned pick_len();
        if ($urandom_range(9) == 0) return $urandom_range(13, 40);
        return $urandom_range(0, 12);
    endfunction

    task automatic push_item(stdb_in_t it);
        while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        tally_item(it);
        items_in++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        count_reg = value;
        restart_tally();
        if (active_count() > peak_count) peak_count = active_count();
    endtask

    task automatic send_table(logic [31:0] tag, int unsigned len, int unsigned noise);
        int unsigned k;
        bit          close_absent;
        bit          closing;
        close_absent = (len == 0) || ($urandom_range(5) == 0);
        for (k = 1; k <= len; k++) begin
            if ($urandom_range(99) < noise)
                push_item(mk_item(stray_tag(tag), 8'($urandom), 1'b0, 1'b0));
            closing = (k == len) && !close_absent;
            push_item(mk_item(closing ? tag : stray_tag(tag), 8'($urandom), 1'b1, closing));
        end
        if (close_absent) push_item(mk_item(tag, 8'($urandom), 1'b0, 1'b1));
    endtask

    task automatic test_directed();
        logic [7:0]  probe_bytes [5] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F};
        int unsigned k;
        // count of one from reset, lone empty table
        push_item(mk_item(32'h0000_0000, 8'hA5, 1'b0, 1'b1));
        // absent byte does nothing, cff tag on a non-closing byte is not counted
        push_item(mk_item(TAG_CFF, 8'hFF, 1'b0, 1'b0));
        push_item(mk_item(TAG_CFF, 8'hFF, 1'b1, 1'b0));
        push_item(mk_item(32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1));
        // zero count acts as one, cff table gives OTTO
        write_count(9'd0);
        for (k = 0; k < 5; k++)
            push_item(mk_item(TAG_CFF, probe_bytes[k], 1'b1, k == 4));
        write_count(9'd3);
        push_item(mk_item(32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1));
        push_item(mk_item(TAG_CFF, 8'h00, 1'b0, 1'b1));
        repeat (5) push_item(mk_item(32'h676C_7966, 8'hFF, 1'b1, 1'b0));
        push_item(mk_item(32'h676C_7966, 8'hFF, 1'b0, 1'b1));
        drain_results();
    endtask

    task automatic test_mid_run_restart();
        write_count(9'd5);
        send_table(pick_tag(), 2, 0);
        send_table(pick_tag(), 1, 0);
        write_count(9'd2);
        send_table(pick_tag(), 3, 0);
        send_table(TAG_CFF, 0, 0);
        drain_results();
    endtask

    task automatic test_count_extremes();
        int unsigned k;
        write_count(9'd511);
        for (k = 0; k < MAX_TABLES; k++) send_table(pick_tag(), $urandom_range(0, 1), 0);
        write_count(9'd256);
        for (k = 0; k < MAX_TABLES; k++) send_table($urandom, 0, 0);
        drain_results();
    endtask

    task automatic test_output_stall();
        int unsigned k;
        write_count(9'd24);
        rx_hold = 400;
        for (k = 0; k < 24; k++) send_table(pick_tag(), $urandom_range(0, 2), 0);
        drain_results();
    endtask

    task automatic test_random_runs(int unsigned target);
        int unsigned first;
        int unsigned done;
        int unsigned tables;
        int unsigned k;
        bit          run_whole;
        first     = items_in;
        run_whole = 1'b0;
        while (items_in - first < target) begin
            done      = items_in - first;
            tx_steady = (done >= target * 2 / 5) && (done < target * 3 / 5);
            rx_steady = tx_steady;
            if (!run_whole || $urandom_range(3) != 0)
                write_count(9'($urandom_range(0, 16)));
            tables    = active_count();
            run_whole = ($urandom_range(9) != 0);
            if (!run_whole) tables = $urandom_range(0, tables - 1);
            for (k = 0; k < tables; k++) send_table(pick_tag(), pick_len(), 8);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        drain_results();
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge aclk) begin : result_check
        stdb_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_records.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected transaction, expected none, actual %h",
                         $time, m_data);
            end else begin
                want = expected_records.pop_front();
                check_field("kind", want.kind, m_data.kind);
                check_field("entry_tag", want.entry_tag, m_data.entry_tag);
                check_field("checksum", want.checksum, m_data.checksum);
                check_field("offset", want.offset, m_data.offset);
                check_field("length", want.length, m_data.length);
                check_field("sfnt_version", want.sfnt_version, m_data.sfnt_version);
                check_field("num_tables", want.num_tables, m_data.num_tables);
                check_field("search_range", want.search_range, m_data.search_range);
                check_field("entry_selector", want.entry_selector, m_data.entry_selector);
                check_field("range_shift", want.range_shift, m_data.range_shift);
                check_field("last", want.last, m_data.last);
                if (want.kind == KIND_HEADER) begin
                    headers_out++;
                    if (want.sfnt_version == VERSION_OTTO) otto_out++;
                end else begin
                    entries_out++;
                end
            end
        end
    end

    // receiver ready
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("sfnt_table_directory_builder_top regression: fail");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        count_reg   = 9'd1;
        restart_tally();
        peak_count  = 1;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_mid_run_restart();
        test_count_extremes();
        test_output_stall();
        test_random_runs(1150);
        drain_results();

        $display("covered %0d input transactions, %0d directory entries, %0d headers (%0d OTTO)",
                 items_in, entries_out, headers_out, otto_out);
        $display("table counts 0 to 16, 24, 256 and 511 (clamped, peak %0d), restarts and stalls",
                 peak_count);
        if (mismatches == 0)
            $display("sfnt_table_directory_builder_top regression: pass");
        else
            $display("sfnt_table_directory_builder_top regression: fail");
        $finish;
    end

endmodule
